/* rtl/core/outlier_rejecting_sample_averager_defines.svh */
// Assertion macros for the outlier rejecting sample averager
`ifndef OUTLIER_REJECTING_SAMPLE_AVERAGER_DEFINES_SVH
`define OUTLIER_REJECTING_SAMPLE_AVERAGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ORSA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ORSA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ORSA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ORSA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/orsa_pkg.sv */
// Shared constants and types for the outlier rejecting sample averager
`timescale 1ns / 1ps
`default_nettype none

package orsa_pkg;

    localparam int SAMPLE_BITS       = 10;
    localparam int CFG_BITS          = 8;
    localparam int ACC_BITS          = SAMPLE_BITS + CFG_BITS;
    localparam int DIV_CNT_BITS      = $clog2(ACC_BITS);
    localparam int REFERENCE_SAMPLES = 5;
    localparam int REJECT_LIMIT      = 3;
    localparam int REJ_BITS          = 3;
    localparam int ADDR_BITS         = 3;
    localparam int DATA_BITS         = 32;

    localparam logic [CFG_BITS-1:0] SAMPLE_COUNT_RESET = 8'd1;
    localparam logic [CFG_BITS-1:0] TOLERANCE_RESET    = 8'd0;

    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_TOLERANCE    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_WARMUP,
        PH_REFERENCE,
        PH_ACCEPT
    } t_phase;

    typedef struct packed {
        logic                start;
        logic [ACC_BITS-1:0] dividend;
        logic [CFG_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/core/orsa_sample_if.sv */
// Sample input channel
`timescale 1ns / 1ps
`default_nettype none

interface orsa_sample_if;
    logic                            valid;
    logic                            ready;
    logic [orsa_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/core/orsa_result_if.sv */
// Result output channel
`timescale 1ns / 1ps
`default_nettype none

interface orsa_result_if;
    logic                            valid;
    logic                            ready;
    logic [orsa_pkg::SAMPLE_BITS-1:0] average;
    logic                            status;

    modport source (output valid, output average, output status, input ready);
    modport sink   (input valid, input average, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/orsa_divider.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module orsa_divider (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire orsa_pkg::t_div_req  i_req,
    output orsa_pkg::t_div_rsp       o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [orsa_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic [orsa_pkg::ACC_BITS-1:0]       r_quo;
    logic [orsa_pkg::CFG_BITS-1:0]       r_rem;
    logic [orsa_pkg::CFG_BITS-1:0]       r_dvs;

    logic [orsa_pkg::CFG_BITS:0]         rem_sh;
    logic [orsa_pkg::CFG_BITS:0]         rem_diff;
    logic                                q_bit;
    logic [orsa_pkg::CFG_BITS-1:0]       n_rem;

    always_comb begin
        rem_sh   = {r_rem, r_quo[orsa_pkg::ACC_BITS-1]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        q_bit    = (rem_sh >= {1'b0, r_dvs});
        n_rem    = q_bit ? rem_diff[orsa_pkg::CFG_BITS-1:0]
                         : rem_sh[orsa_pkg::CFG_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == orsa_pkg::DIV_CNT_BITS'(orsa_pkg::ACC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[orsa_pkg::ACC_BITS-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/core/outlier_rejecting_sample_averager.sv */
// Top level of the outlier rejecting sample averager
// Usage:
//   Samples arrive on i_sample_ch (valid/ready); one beat carries one 10-bit
//   converter result. Readings leave on o_result_ch as average plus status
//   (0 done, 1 too many outliers, average then 0).
//   A reading discards five warm-up samples, averages five more into a
//   reference, then sums samples strictly inside reference +/- tolerance
//   until sample_count of them are taken, 0 counting as 1. The fourth
//   rejection fails it. sample_count and tolerance sit on the APB port at
//   byte 0 and 4; write them only while no reading is in progress.
// Input flow:
//   The input is ready whenever the block is idle. The fifth reference sample
//   and the sample that completes a reading hold the input while they run
//   the shared restoring divider, one quotient bit at a time. A result goes
//   from the divider into the result register and on to the output register;
//   a rejection that fails the reading writes the result register directly.
// Reset and stalls:
//   Synchronous reset sets sample_count 1, tolerance 0 and starts a reading.
//   A result waits in the output register while the receiver stalls; samples
//   keep flowing until a second result is ready, which then holds the block.
`timescale 1ns / 1ps
`default_nettype none
`include "outlier_rejecting_sample_averager_defines.svh"

module outlier_rejecting_sample_averager (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    orsa_sample_if.sink                         i_sample_ch,
    orsa_result_if.source                       o_result_ch,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [orsa_pkg::ADDR_BITS-1:0]      paddr,
    input  wire  [orsa_pkg::DATA_BITS-1:0]      pwdata,
    output logic [orsa_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    localparam int SB = orsa_pkg::SAMPLE_BITS;
    localparam int CB = orsa_pkg::CFG_BITS;
    localparam int AB = orsa_pkg::ACC_BITS;
    localparam int RB = orsa_pkg::REJ_BITS;

    orsa_pkg::t_state     r_state, n_state;
    orsa_pkg::t_phase     r_phase, n_phase;
    logic [CB-1:0]        r_cnt, n_cnt;
    logic [AB-1:0]        r_acc, n_acc;
    logic [SB-1:0]        r_ref, n_ref;
    logic [RB-1:0]        r_rej, n_rej;
    logic [SB-1:0]        r_res_avg, n_res_avg;
    logic                 r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [SB-1:0]        r_out_avg, n_out_avg;
    logic                 r_out_status, n_out_status;
    logic [CB-1:0]        r_sample_count;
    logic [CB-1:0]        r_tolerance;

    orsa_pkg::t_div_req   div_req;
    orsa_pkg::t_div_rsp   div_rsp;

    logic                 in_beat;
    logic                 out_free;
    logic [SB-1:0]        s;
    logic [CB-1:0]        n_eff;
    logic [AB-1:0]        acc_sum;
    logic [CB:0]          cnt_inc;
    logic [RB:0]          rej_inc;
    logic [SB:0]          hi;
    logic [SB-1:0]        lo;
    logic                 accepted;

    orsa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= orsa_pkg::SAMPLE_COUNT_RESET;
            r_tolerance    <= orsa_pkg::TOLERANCE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                orsa_pkg::REG_SAMPLE_COUNT: r_sample_count <= pwdata[CB-1:0];
                orsa_pkg::REG_TOLERANCE:    r_tolerance    <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            orsa_pkg::REG_SAMPLE_COUNT: prdata = orsa_pkg::DATA_BITS'(r_sample_count);
            orsa_pkg::REG_TOLERANCE:    prdata = orsa_pkg::DATA_BITS'(r_tolerance);
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign i_sample_ch.ready   = (r_state == orsa_pkg::ST_IDLE);
    assign o_result_ch.valid   = r_out_valid;
    assign o_result_ch.average = r_out_avg;
    assign o_result_ch.status  = r_out_status;

    assign in_beat  = i_sample_ch.valid && i_sample_ch.ready;
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign s        = i_sample_ch.sample;

    always_comb begin
        n_eff    = (r_sample_count == '0) ? CB'(1) : r_sample_count;
        acc_sum  = r_acc + AB'(s);
        cnt_inc  = {1'b0, r_cnt} + 1'b1;
        rej_inc  = {1'b0, r_rej} + 1'b1;
        hi       = {1'b0, r_ref} + (SB+1)'(r_tolerance);
        lo       = (r_ref > SB'(r_tolerance)) ? (r_ref - SB'(r_tolerance)) : '0;
        accepted = (s > lo) && ((SB+1)'(s) < hi);
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_ref        = r_ref;
        n_rej        = r_rej;
        n_res_avg    = r_res_avg;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_avg    = r_out_avg;
        n_out_status = r_out_status;

        div_req.start    = 1'b0;
        div_req.dividend = acc_sum;
        div_req.divisor  = n_eff;

        if (r_out_valid && o_result_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            orsa_pkg::ST_IDLE: begin
                if (in_beat) begin
                    case (r_phase)
                        orsa_pkg::PH_WARMUP: begin
                            n_cnt = cnt_inc[CB-1:0];
                            if (cnt_inc >= (CB+1)'(orsa_pkg::REFERENCE_SAMPLES)) begin
                                n_phase = orsa_pkg::PH_REFERENCE;
                                n_cnt   = '0;
                                n_acc   = '0;
                            end
                        end
                        orsa_pkg::PH_REFERENCE: begin
                            n_acc = acc_sum;
                            n_cnt = cnt_inc[CB-1:0];
                            if (cnt_inc >= (CB+1)'(orsa_pkg::REFERENCE_SAMPLES)) begin
                                div_req.start   = 1'b1;
                                div_req.divisor = CB'(orsa_pkg::REFERENCE_SAMPLES);
                                n_state         = orsa_pkg::ST_DIV;
                            end
                        end
                        orsa_pkg::PH_ACCEPT: begin
                            if (accepted) begin
                                n_acc = acc_sum;
                                n_cnt = cnt_inc[CB-1:0];
                                if (cnt_inc >= {1'b0, n_eff}) begin
                                    div_req.start = 1'b1;
                                    n_state       = orsa_pkg::ST_DIV;
                                end
                            end else begin
                                n_rej = rej_inc[RB-1:0];
                                if (rej_inc > (RB+1)'(orsa_pkg::REJECT_LIMIT)) begin
                                    n_res_avg    = '0;
                                    n_res_status = 1'b1;
                                    n_phase      = orsa_pkg::PH_WARMUP;
                                    n_cnt        = '0;
                                    n_acc        = '0;
                                    n_ref        = '0;
                                    n_rej        = '0;
                                    n_state      = orsa_pkg::ST_WAIT;
                                end
                            end
                        end
                        default: begin
                            n_phase = orsa_pkg::PH_WARMUP;
                        end
                    endcase
                end
            end
            orsa_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    if (r_phase == orsa_pkg::PH_REFERENCE) begin
                        n_ref   = div_rsp.quotient[SB-1:0];
                        n_phase = orsa_pkg::PH_ACCEPT;
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_rej   = '0;
                        n_state = orsa_pkg::ST_IDLE;
                    end else begin
                        n_res_avg    = div_rsp.quotient[SB-1:0];
                        n_res_status = 1'b0;
                        n_phase      = orsa_pkg::PH_WARMUP;
                        n_cnt        = '0;
                        n_acc        = '0;
                        n_ref        = '0;
                        n_rej        = '0;
                        n_state      = orsa_pkg::ST_WAIT;
                    end
                end
            end
            orsa_pkg::ST_WAIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_avg    = r_res_avg;
                    n_out_status = r_res_status;
                    n_state      = orsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = orsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orsa_pkg::ST_IDLE;
            r_phase     <= orsa_pkg::PH_WARMUP;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_ref       <= '0;
            r_rej       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_ref       <= n_ref;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_avg    <= n_res_avg;
        r_res_status <= n_res_status;
        r_out_avg    <= n_out_avg;
        r_out_status <= n_out_status;
    end

    `ORSA_ASSERT_IMPLY(a_div_done_in_div, i_clk, i_rst_n,
        div_rsp.done, r_state == orsa_pkg::ST_DIV,
        "divider finished outside divide state")
    `ORSA_ASSERT_IMPLY(a_fail_zero_avg, i_clk, i_rst_n,
        o_result_ch.valid && o_result_ch.status, o_result_ch.average == '0,
        "failure beat with nonzero average")
    `ORSA_ASSERT_ALWAYS(a_rej_bound, i_clk, i_rst_n,
        r_rej <= RB'(orsa_pkg::REJECT_LIMIT),
        "rejection count beyond limit")

endmodule

`default_nettype wire

/* verif/outlier_rejecting_sample_averager_tb.sv */
// Self-checking testbench for the outlier rejecting sample averager
`timescale 1ns / 1ps

module outlier_rejecting_sample_averager_tb;
    import orsa_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 27;
    localparam int N_DIRECTED   = 28;

    typedef enum logic { ROW_SAMPLE, ROW_CONFIG } row_kind_e;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   status;
    } reading_t;

    typedef struct packed {
        row_kind_e              kind;
        logic                   regsel;
        logic [CFG_BITS-1:0]    value;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        logic [SAMPLE_BITS-1:0] average;
        logic                   status;
    } row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [DATA_BITS-1:0]   pwdata;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;

    orsa_sample_if smp_ch ();
    orsa_result_if res_ch ();

    outlier_rejecting_sample_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [CFG_BITS-1:0]    cfg_count;
    logic [CFG_BITS-1:0]    cfg_tol;
    t_phase                 cur_phase;
    logic [7:0]             phase_cnt;
    logic [ACC_BITS-1:0]    acc;
    logic [SAMPLE_BITS-1:0] ref_val;
    logic [REJ_BITS-1:0]    rej_cnt;

    reading_t pending_readings [$];
    int       mismatches;
    int       cycle_count;
    int       src_idle_pct;
    int       sink_idle_pct;
    int       hold_left;
    bit       hold_req;
    int       reading_center;

    // zero tolerance failure after reset, then zero count with an empty lower window
    row_t directed_rows [N_DIRECTED] = '{
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd1023, 1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd682,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd341,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd512,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd100,  1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd1023, 1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd99,   1'b1, 10'd0, 1'b1},
        '{ROW_CONFIG, REG_SAMPLE_COUNT, 8'd0,   10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_CONFIG, REG_TOLERANCE,    8'd255, 10'd0, 1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd1023, 1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd1023, 1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd5,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd0,    1'b0, 10'd0, 1'b0},
        '{ROW_SAMPLE, 1'b0, 8'd0, 10'd1,    1'b1, 10'd1, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic restart_reading();
        cur_phase = PH_WARMUP;
        phase_cnt = '0;
        acc       = '0;
        ref_val   = '0;
        rej_cnt   = '0;
    endtask

    task automatic advance_reading(input logic [SAMPLE_BITS-1:0] s, output bit done,
                                   output reading_t rd);
        logic [CFG_BITS-1:0]    n;
        logic [SAMPLE_BITS:0]   hi;
        logic [SAMPLE_BITS-1:0] lo;
        logic [ACC_BITS-1:0]    q;
        done = 1'b0;
        rd   = '0;
        case (cur_phase)
            PH_WARMUP: begin
                phase_cnt++;
                if (phase_cnt >= REFERENCE_SAMPLES) begin
                    cur_phase = PH_REFERENCE;
                    phase_cnt = '0;
                    acc       = '0;
                end
            end
            PH_REFERENCE: begin
                acc += s;
                phase_cnt++;
                if (phase_cnt >= REFERENCE_SAMPLES) begin
                    q         = acc / REFERENCE_SAMPLES;
                    ref_val   = q[SAMPLE_BITS-1:0];
                    cur_phase = PH_ACCEPT;
                    phase_cnt = '0;
                    acc       = '0;
                    rej_cnt   = '0;
                end
            end
            default: begin
                n  = (cfg_count == 0) ? 8'd1 : cfg_count;
                hi = {1'b0, ref_val} + cfg_tol;
                lo = (ref_val > cfg_tol) ? ref_val - cfg_tol : '0;
                if (s > lo && {1'b0, s} < hi) begin
                    acc += s;
                    phase_cnt++;
                    if (phase_cnt >= n) begin
                        q          = acc / n;
                        rd.average = q[SAMPLE_BITS-1:0];
                        rd.status  = 1'b0;
                        done       = 1'b1;
                        restart_reading();
                    end
                end else begin
                    rej_cnt++;
                    if (rej_cnt > REJECT_LIMIT) begin
                        rd.average = '0;
                        rd.status  = 1'b1;
                        done       = 1'b1;
                        restart_reading();
                    end
                end
            end
        endcase
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int outlier_pct);
        int lo;
        int hi;
        int top;
        int c;
        int r;
        int t;
        if (cur_phase == PH_WARMUP && phase_cnt == 0) begin
            case ($urandom_range(9))
                0: reading_center = 0;
                1: reading_center = 1023;
                default: reading_center = $urandom_range(1023);
            endcase
        end
        if (cur_phase == PH_WARMUP || $urandom_range(199) < outlier_pct)
            return SAMPLE_BITS'($urandom_range(1023));
        if (cur_phase == PH_REFERENCE) begin
            c = reading_center + int'($urandom_range(6)) - 3;
            c = (c < 0) ? 0 : (c > 1023) ? 1023 : c;
            return SAMPLE_BITS'(c);
        end
        r   = ref_val;
        t   = cfg_tol;
        lo  = (r > t) ? r - t : 0;
        hi  = r + t;
        top = (hi - 1 > 1023) ? 1023 : hi - 1;
        if ($urandom_range(99) >= outlier_pct && lo + 1 <= top)
            return SAMPLE_BITS'($urandom_range(top, lo + 1));
        if (hi <= 1023 && $urandom_range(1))
            return SAMPLE_BITS'($urandom_range(1023, hi));
        return SAMPLE_BITS'($urandom_range(lo, 0));
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                               input reading_t typed_rd);
        bit       done;
        reading_t rd;
        while ($urandom_range(99) < src_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        do @(posedge i_clk); while (!smp_ch.ready);
        advance_reading(s, done, rd);
        if (typed)
            pending_readings.push_back(typed_rd);
        else if (done)
            pending_readings.push_back(rd);
    endtask

    task automatic wait_results(input int extra);
        smp_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic regsel, input logic [CFG_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_BITS'(value)) begin
            mismatches++;
            $display("%0t: register %0d read back expected %0d got %0d",
                     $time, regsel, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (regsel == REG_SAMPLE_COUNT)
            cfg_count = value;
        else
            cfg_tol = value;
    endtask

    // ends on a reading boundary: sample 0 is always an outlier once accepting
    task automatic finish_reading();
        while (!(cur_phase == PH_WARMUP && phase_cnt == 0)) begin
            if (cur_phase == PH_ACCEPT)
                send_sample('0, 1'b0, '0);
            else
                send_sample(SAMPLE_BITS'($urandom_range(1023)), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] count, input logic [CFG_BITS-1:0] tol,
                             input int items, input int outlier_pct, input bit hold);
        wait_results(DRAIN_CYCLES);
        write_reg(REG_SAMPLE_COUNT, count);
        write_reg(REG_TOLERANCE, tol);
        if (hold)
            hold_req = 1'b1;
        for (int i = 0; i < items; i++) begin
            if (i == items / 2)
                wait_results(0);
            send_sample(pick_sample(outlier_pct), 1'b0, '0);
        end
        finish_reading();
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial begin
        reading_t exp_rd;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat expected none got average %0d status %0d",
                             $time, res_ch.average, res_ch.status);
                end else begin
                    exp_rd = pending_readings.pop_front();
                    if (res_ch.average !== exp_rd.average) begin
                        mismatches++;
                        $display("%0t: average expected %0d got %0d",
                                 $time, exp_rd.average, res_ch.average);
                    end
                    if (res_ch.status !== exp_rd.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, exp_rd.status, res_ch.status);
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("outlier_rejecting_sample_averager: mismatch");
        $finish;
    end

    initial begin
        row_t row;
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        hold_req      = 1'b0;
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        reading_center = 0;
        cfg_count     = SAMPLE_COUNT_RESET;
        cfg_tol       = TOLERANCE_RESET;
        restart_reading();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG) begin
                wait_results(DRAIN_CYCLES);
                write_reg(row.regsel, row.value);
            end else begin
                send_sample(row.sample, row.typed, '{row.average, row.status});
            end
        end

        run_phase(8'd1, 8'd0, 40, 40, 1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(8'd4, 8'd30, 80, 15, 1'b0);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        run_phase(8'd0, 8'd12, 40, 20, 1'b0);
        run_phase(8'd2, 8'd255, 60, 20, 1'b1);
        run_phase(8'd255, 8'd255, 280, 1, 1'b0);
        run_phase(CFG_BITS'($urandom_range(12, 1)), CFG_BITS'($urandom_range(255)), 40, 20, 1'b0);
        run_phase(CFG_BITS'($urandom_range(12, 1)), CFG_BITS'($urandom_range(255)), 40, 20, 1'b0);

        wait_results(DRAIN_CYCLES);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("outlier_rejecting_sample_averager: match");
        end else begin
            $display("outlier_rejecting_sample_averager: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/orsa_pkg.sv
rtl/core/orsa_sample_if.sv
rtl/core/orsa_result_if.sv
rtl/core/orsa_divider.sv
rtl/core/outlier_rejecting_sample_averager.sv
verif/outlier_rejecting_sample_averager_tb.sv
